>>> hw/rtl/bts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_pkg
// Shared types and constants of the banded triangular solve unit.
// ----------------------------------------------------------------------------
package bts_pkg;

    // fixed field widths
    localparam int COEF_W = 32;
    localparam int OPND_W = 33;
    localparam int PROD_W = 66;
    localparam int ACC_W  = 101;

    // multiply-accumulate program length
    localparam int NSTEP  = 22;
    localparam int STEP_W = 5;

    // status codes
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_SAT  = 2'd1;
    localparam logic [1:0] STAT_ZERO = 2'd2;

    // register map
    localparam int          PADDR_W        = 3;
    localparam logic        REG_BAND_ORDER = 1'b0;
    localparam logic [1:0]  ORDER_TWO      = 2'd2;
    localparam logic [1:0]  ORDER_RESET    = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_DIV_LOAD,
        S_DIV_RUN,
        S_DIV_ROUND,
        S_FINISH
    } t_state;

    typedef enum logic [2:0] {
        ACC_NR,
        ACC_NI,
        ACC_DEN,
        ACC_PR,
        ACC_PI
    } t_acc;

endpackage

>>> hw/rtl/bts_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_if
// Row and solution channels of the banded triangular solve unit.
// ----------------------------------------------------------------------------
interface bts_row_if;
    logic               valid;
    logic               ready;
    logic               first_row;
    logic signed [31:0] diag_re;
    logic signed [31:0] diag_im;
    logic signed [31:0] off1_re;
    logic signed [31:0] off1_im;
    logic signed [31:0] off2_re;
    logic signed [31:0] off2_im;
    logic signed [31:0] rhs_re;
    logic signed [31:0] rhs_im;

    modport source (output valid, first_row, diag_re, diag_im, off1_re, off1_im,
                    off2_re, off2_im, rhs_re, rhs_im, input ready);
    modport sink (input valid, first_row, diag_re, diag_im, off1_re, off1_im,
                  off2_re, off2_im, rhs_re, rhs_im, output ready);
endinterface

interface bts_sol_if #(parameter int DATA_WIDTH = 32);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] x_re;
    logic signed [DATA_WIDTH-1:0] x_im;
    logic [1:0]                   status;

    modport source (output valid, x_re, x_im, status, input ready);
    modport sink (input valid, x_re, x_im, status, output ready);
endinterface

>>> hw/rtl/banded_triangular_solve_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// banded_triangular_solve_unit
// Complex banded forward/back substitution, one row per beat, Q16.16.
// Each row takes 22 passes of the shared 33x33 multiplier and a drain state,
// then a one-bit-per-cycle restoring divider run once for the real and once
// for the imaginary part; a part that saturates early or a zero diagonal ends
// sooner. A new row is taken only once the unit is back in idle, which comes
// later while a solution beat is held off.
// Reset: synchronous active low; history cleared, band order set to one.
// ----------------------------------------------------------------------------
module banded_triangular_solve_unit #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    bts_row_if.sink                     i_row,
    bts_sol_if.source                   o_sol,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [bts_pkg::PADDR_W-1:0] i_paddr,
    input  logic [31:0]                 i_pwdata,
    output logic [31:0]                 o_prdata,
    output logic                        o_pready
);

    localparam int DW  = DATA_WIDTH;
    localparam int PW  = bts_pkg::ACC_W;
    localparam int CW  = (PW > 64 + DW) ? PW : 64 + DW;
    localparam int CNW = $clog2(DW);
    localparam logic [DW:0] POS_LIM = {2'b00, {(DW-1){1'b1}}};
    localparam logic [DW:0] NEG_LIM = POS_LIM + 1'b1;

    bts_pkg::t_state r_state, n_state;

    logic [1:0]               r_order;
    logic signed [31:0]       r_p1r, r_p1i, r_p2r, r_p2i;
    logic signed [31:0]       r_dr, r_di, r_c1r, r_c1i, r_c2r, r_c2i;
    logic [bts_pkg::STEP_W-1:0] r_step;
    logic signed [PW-1:0]     r_nr, r_ni, r_den, r_pr, r_pi;

    logic signed [bts_pkg::PROD_W-1:0] r_prod;
    logic                     r_pv;
    bts_pkg::t_acc            r_pacc;
    logic                     r_psub;
    logic [1:0]               r_psh;

    logic                     r_comp, r_neg, r_sat;
    logic [63:0]              r_rem;
    logic [DW-1:0]            r_low, r_q, r_xr, r_xi;
    logic [CNW-1:0]           r_cnt;

    logic                     r_ov;
    logic [DW-1:0]            r_ore, r_oim;
    logic [1:0]               r_ost;

    logic in_acc, cfg_wr;
    logic signed [bts_pkg::OPND_W-1:0] m_a, m_b;
    bts_pkg::t_acc u_acc;
    logic          u_sub;
    logic [1:0]    u_sh;
    logic signed [31:0] x2r_e, x2i_e;
    logic signed [bts_pkg::OPND_W-1:0] nr_l0, nr_l1, nr_l2, ni_l0, ni_l1, ni_l2;
    logic signed [bts_pkg::OPND_W-1:0] dr_e, di_e;
    logic signed [PW-1:0] addend;

    logic signed [PW-1:0] d_p;
    logic                 d_neg;
    logic [PW-1:0]        d_mag;
    logic [CW-1:0]        d_cmag, d_cden;
    logic                 d_ovf, d_zero;
    logic [63:0]          d_den;
    logic [64:0]          d_rem2;
    logic                 d_ge;
    logic [DW:0]          d_qr, d_lim, d_qf;
    logic                 d_rsat;
    logic [DW-1:0]        d_val, d_ovf_val;

    assign in_acc      = i_row.valid && i_row.ready;
    assign i_row.ready = (r_state == bts_pkg::S_IDLE);
    assign cfg_wr      = i_psel && i_penable && i_pwrite;
    assign o_pready    = 1'b1;
    assign o_prdata    = (i_paddr[2] == bts_pkg::REG_BAND_ORDER) ? {30'd0, r_order} : 32'd0;

    assign o_sol.valid  = r_ov;
    assign o_sol.x_re   = r_ore;
    assign o_sol.x_im   = r_oim;
    assign o_sol.status = r_ost;

    // multiplier operands: gated second history, numerator limbs, diagonal
    assign x2r_e = (r_order == bts_pkg::ORDER_TWO) ? r_p2r : 32'sd0;
    assign x2i_e = (r_order == bts_pkg::ORDER_TWO) ? r_p2i : 32'sd0;
    assign nr_l0 = {1'b0, r_nr[31:0]};
    assign nr_l1 = {1'b0, r_nr[63:32]};
    assign nr_l2 = {{30{r_nr[66]}}, r_nr[66:64]};
    assign ni_l0 = {1'b0, r_ni[31:0]};
    assign ni_l1 = {1'b0, r_ni[63:32]};
    assign ni_l2 = {{30{r_ni[66]}}, r_ni[66:64]};
    assign dr_e  = bts_pkg::OPND_W'(r_dr);
    assign di_e  = bts_pkg::OPND_W'(r_di);

    // multiply program
    always_comb begin
        m_a   = '0;
        m_b   = '0;
        u_acc = bts_pkg::ACC_NR;
        u_sub = 1'b0;
        u_sh  = 2'd0;
        case (r_step)
            5'd0:  begin m_a = 33'(r_c1r); m_b = 33'(r_p1r); u_sub = 1'b1; end
            5'd1:  begin m_a = 33'(r_c1i); m_b = 33'(r_p1i); end
            5'd2:  begin m_a = 33'(r_c1r); m_b = 33'(r_p1i); u_acc = bts_pkg::ACC_NI;
                         u_sub = 1'b1; end
            5'd3:  begin m_a = 33'(r_c1i); m_b = 33'(r_p1r); u_acc = bts_pkg::ACC_NI;
                         u_sub = 1'b1; end
            5'd4:  begin m_a = 33'(r_c2r); m_b = 33'(x2r_e); u_sub = 1'b1; end
            5'd5:  begin m_a = 33'(r_c2i); m_b = 33'(x2i_e); end
            5'd6:  begin m_a = 33'(r_c2r); m_b = 33'(x2i_e); u_acc = bts_pkg::ACC_NI;
                         u_sub = 1'b1; end
            5'd7:  begin m_a = 33'(r_c2i); m_b = 33'(x2r_e); u_acc = bts_pkg::ACC_NI;
                         u_sub = 1'b1; end
            5'd8:  begin m_a = dr_e; m_b = dr_e; u_acc = bts_pkg::ACC_DEN; end
            5'd9:  begin m_a = di_e; m_b = di_e; u_acc = bts_pkg::ACC_DEN; end
            5'd10: begin m_a = nr_l0; m_b = dr_e; u_acc = bts_pkg::ACC_PR; end
            5'd11: begin m_a = nr_l1; m_b = dr_e; u_acc = bts_pkg::ACC_PR; u_sh = 2'd1; end
            5'd12: begin m_a = nr_l2; m_b = dr_e; u_acc = bts_pkg::ACC_PR; u_sh = 2'd2; end
            5'd13: begin m_a = ni_l0; m_b = di_e; u_acc = bts_pkg::ACC_PR; end
            5'd14: begin m_a = ni_l1; m_b = di_e; u_acc = bts_pkg::ACC_PR; u_sh = 2'd1; end
            5'd15: begin m_a = ni_l2; m_b = di_e; u_acc = bts_pkg::ACC_PR; u_sh = 2'd2; end
            5'd16: begin m_a = ni_l0; m_b = dr_e; u_acc = bts_pkg::ACC_PI; end
            5'd17: begin m_a = ni_l1; m_b = dr_e; u_acc = bts_pkg::ACC_PI; u_sh = 2'd1; end
            5'd18: begin m_a = ni_l2; m_b = dr_e; u_acc = bts_pkg::ACC_PI; u_sh = 2'd2; end
            5'd19: begin m_a = nr_l0; m_b = di_e; u_acc = bts_pkg::ACC_PI; u_sub = 1'b1; end
            5'd20: begin m_a = nr_l1; m_b = di_e; u_acc = bts_pkg::ACC_PI; u_sub = 1'b1;
                         u_sh = 2'd1; end
            5'd21: begin m_a = nr_l2; m_b = di_e; u_acc = bts_pkg::ACC_PI; u_sub = 1'b1;
                         u_sh = 2'd2; end
            default: begin m_a = '0; m_b = '0; end
        endcase
    end

    // shifted addend of the registered product
    always_comb begin
        case (r_psh)
            2'd1:    addend = PW'(r_prod) <<< 32;
            2'd2:    addend = PW'(r_prod) <<< 64;
            default: addend = PW'(r_prod);
        endcase
    end

    // divider datapath
    assign d_den     = r_den[63:0];
    assign d_zero    = (d_den == 64'd0);
    assign d_p       = r_comp ? r_pi : r_pr;
    assign d_neg     = d_p[PW-1];
    assign d_mag     = d_neg ? PW'(-d_p) : PW'(d_p);
    assign d_cmag    = CW'(d_mag);
    assign d_cden    = CW'(d_den) << DW;
    assign d_ovf     = (d_cmag >= d_cden);
    assign d_ovf_val = d_neg ? DW'(-NEG_LIM) : DW'(POS_LIM);
    assign d_rem2    = {r_rem, r_low[DW-1]};
    assign d_ge      = (d_rem2 >= {1'b0, d_den});
    assign d_qr      = {1'b0, r_q} + (DW+1)'({r_rem, 1'b0} >= {1'b0, d_den});
    assign d_lim     = r_neg ? NEG_LIM : POS_LIM;
    assign d_rsat    = (d_qr > d_lim);
    assign d_qf      = d_rsat ? d_lim : d_qr;
    assign d_val     = r_neg ? DW'(-d_qf) : DW'(d_qf);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bts_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bts_pkg::S_IDLE: begin
                if (in_acc) n_state = bts_pkg::S_MAC;
            end
            bts_pkg::S_MAC: begin
                if (r_step == bts_pkg::STEP_W'(bts_pkg::NSTEP - 1)) n_state = bts_pkg::S_DRAIN;
            end
            bts_pkg::S_DRAIN: n_state = bts_pkg::S_DIV_LOAD;
            bts_pkg::S_DIV_LOAD: begin
                if (d_zero) n_state = bts_pkg::S_FINISH;
                else if (!d_ovf) n_state = bts_pkg::S_DIV_RUN;
                else if (r_comp) n_state = bts_pkg::S_FINISH;
            end
            bts_pkg::S_DIV_RUN: begin
                if (r_cnt == CNW'(DW - 1)) n_state = bts_pkg::S_DIV_ROUND;
            end
            bts_pkg::S_DIV_ROUND: begin
                n_state = r_comp ? bts_pkg::S_FINISH : bts_pkg::S_DIV_LOAD;
            end
            bts_pkg::S_FINISH: begin
                if (!r_ov || o_sol.ready) n_state = bts_pkg::S_IDLE;
            end
            default: n_state = bts_pkg::S_IDLE;
        endcase
    end

    // control registers: band order, history, step counter, product valid, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= bts_pkg::ORDER_RESET;
            r_p1r   <= '0;
            r_p1i   <= '0;
            r_p2r   <= '0;
            r_p2i   <= '0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
            r_step  <= '0;
        end else begin
            if (cfg_wr && i_paddr[2] == bts_pkg::REG_BAND_ORDER) r_order <= i_pwdata[1:0];
            // drop history on a new system
            if (in_acc && i_row.first_row) begin
                r_p1r <= '0;
                r_p1i <= '0;
                r_p2r <= '0;
                r_p2i <= '0;
            end
            r_pv <= (r_state == bts_pkg::S_MAC);
            if (in_acc) r_step <= '0;
            else if (r_state == bts_pkg::S_MAC) r_step <= r_step + 1'b1;
            if (o_sol.ready) r_ov <= 1'b0;
            // emit and shift the solution into the history
            if (r_state == bts_pkg::S_FINISH && (!r_ov || o_sol.ready)) begin
                r_ov  <= 1'b1;
                r_p2r <= r_p1r;
                r_p2i <= r_p1i;
                r_p1r <= 32'(r_xr);
                r_p1i <= 32'(r_xi);
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= m_a * m_b;
        r_pacc <= u_acc;
        r_psub <= u_sub;
        r_psh  <= u_sh;

        if (in_acc) begin
            r_dr  <= i_row.diag_re;
            r_di  <= i_row.diag_im;
            r_c1r <= i_row.off1_re;
            r_c1i <= i_row.off1_im;
            r_c2r <= i_row.off2_re;
            r_c2i <= i_row.off2_im;
            r_nr  <= PW'(i_row.rhs_re) <<< 16;
            r_ni  <= PW'(i_row.rhs_im) <<< 16;
            r_den <= '0;
            r_pr  <= '0;
            r_pi  <= '0;
            r_comp <= 1'b0;
            r_sat  <= 1'b0;
        end else if (r_pv) begin
            // accumulate the registered product
            case (r_pacc)
                bts_pkg::ACC_NR:  r_nr  <= r_psub ? r_nr - addend : r_nr + addend;
                bts_pkg::ACC_NI:  r_ni  <= r_psub ? r_ni - addend : r_ni + addend;
                bts_pkg::ACC_DEN: r_den <= r_den + addend;
                bts_pkg::ACC_PR:  r_pr  <= r_psub ? r_pr - addend : r_pr + addend;
                bts_pkg::ACC_PI:  r_pi  <= r_psub ? r_pi - addend : r_pi + addend;
                default:          r_nr  <= r_nr;
            endcase
        end

        case (r_state)
            bts_pkg::S_DIV_LOAD: begin
                if (d_zero) begin
                    r_xr <= '0;
                    r_xi <= '0;
                end else if (d_ovf) begin
                    r_sat  <= 1'b1;
                    r_comp <= 1'b1;
                    if (r_comp) r_xi <= d_ovf_val;
                    else        r_xr <= d_ovf_val;
                end else begin
                    r_rem <= 64'(d_mag >> DW);
                    r_low <= d_mag[DW-1:0];
                    r_q   <= '0;
                    r_cnt <= '0;
                    r_neg <= d_neg;
                end
            end
            // one quotient bit per cycle
            bts_pkg::S_DIV_RUN: begin
                r_rem <= d_ge ? 64'(d_rem2 - {1'b0, d_den}) : d_rem2[63:0];
                r_low <= r_low << 1;
                r_q   <= {r_q[DW-2:0], d_ge};
                r_cnt <= r_cnt + 1'b1;
            end
            // round half away from zero, then saturate
            bts_pkg::S_DIV_ROUND: begin
                if (d_rsat) r_sat <= 1'b1;
                if (r_comp) r_xi <= d_val;
                else        r_xr <= d_val;
                r_comp <= 1'b1;
            end
            bts_pkg::S_FINISH: begin
                if (!r_ov || o_sol.ready) begin
                    r_ore <= r_xr;
                    r_oim <= r_xi;
                    r_ost <= d_zero ? bts_pkg::STAT_ZERO
                           : (r_sat ? bts_pkg::STAT_SAT : bts_pkg::STAT_OK);
                end
            end
            default: r_cnt <= r_cnt;
        endcase
    end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the banded triangular solve unit. Rows are driven
// through the row channel, first from a directed table and then at random
// over several band orders and idle/stall mixes. Each accepted row is run
// through a local complex substitution predictor, and every solution beat is
// compared field by field against the oldest queued solution.
// ----------------------------------------------------------------------------
module testbench;

    localparam int DW = 32;
    localparam logic [bts_pkg::PADDR_W-1:0] BAND_ADDR =
        bts_pkg::PADDR_W'(4 * bts_pkg::REG_BAND_ORDER);

    typedef struct packed {
        logic               first_row;
        logic signed [31:0] d_re, d_im, c1_re, c1_im, c2_re, c2_im, b_re, b_im;
    } t_row;

    typedef struct packed {
        logic signed [DW-1:0] x_re, x_im;
        logic [1:0]           status;
    } t_sol;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_psel = 1'b0, i_penable = 1'b0, i_pwrite = 1'b0;
    logic [bts_pkg::PADDR_W-1:0] i_paddr = '0;
    logic [31:0] i_pwdata = '0;
    logic [31:0] o_prdata;
    logic o_pready;

    bts_row_if row_bus ();
    bts_sol_if #(.DATA_WIDTH(DW)) sol_bus ();

    banded_triangular_solve_unit #(.DATA_WIDTH(DW)) u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_row     (row_bus),
        .o_sol     (sol_bus),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state and bench bookkeeping
    logic [1:0]         band_order;
    logic signed [31:0] hist1_re, hist1_im, hist2_re, hist2_im;
    t_sol               solution_q[$];
    int                 fail_cnt = 0;
    int                 stall_pct = 0;
    int                 hold_cycles = 0;
    logic               typed_flag = 1'b0;
    t_sol               typed_sol;

    function automatic logic signed [127:0] wide(input logic signed [31:0] v);
        return v;
    endfunction

    // divide with rounding half away from zero, saturate to the output range
    function automatic logic [DW-1:0] round_div(input logic signed [127:0] num,
                                                input logic [127:0] den,
                                                inout logic sat);
        logic         neg;
        logic [127:0] mag, quo, rem, lim;
        neg = num < 0;
        mag = neg ? -num : num;
        quo = mag / den;
        rem = mag % den;
        if (rem >= den - rem) quo = quo + 1;
        lim = neg ? (128'd1 << (DW - 1)) : ((128'd1 << (DW - 1)) - 1);
        if (quo > lim) begin
            sat = 1'b1;
            quo = lim;
        end
        return neg ? DW'(-quo) : DW'(quo);
    endfunction

    // one substitution step: x = (b - c1*x1 - c2*x2) / d, history shifted
    function automatic t_sol solve_row(input t_row r);
        logic signed [127:0] nr, ni, pr, pi;
        logic [127:0]        den;
        logic                sat;
        t_sol                s;
        sat = 1'b0;
        if (r.first_row) begin
            hist1_re = 0; hist1_im = 0; hist2_re = 0; hist2_im = 0;
        end
        nr = wide(r.b_re) * 65536 - (wide(r.c1_re) * wide(hist1_re)
             - wide(r.c1_im) * wide(hist1_im));
        ni = wide(r.b_im) * 65536 - (wide(r.c1_re) * wide(hist1_im)
             + wide(r.c1_im) * wide(hist1_re));
        if (band_order == bts_pkg::ORDER_TWO) begin
            nr = nr - (wide(r.c2_re) * wide(hist2_re) - wide(r.c2_im) * wide(hist2_im));
            ni = ni - (wide(r.c2_re) * wide(hist2_im) + wide(r.c2_im) * wide(hist2_re));
        end
        den = wide(r.d_re) * wide(r.d_re) + wide(r.d_im) * wide(r.d_im);
        if (den == 0) begin
            s.x_re = '0;
            s.x_im = '0;
            s.status = bts_pkg::STAT_ZERO;
        end else begin
            pr = nr * wide(r.d_re) + ni * wide(r.d_im);
            pi = ni * wide(r.d_re) - nr * wide(r.d_im);
            s.x_re = round_div(pr, den, sat);
            s.x_im = round_div(pi, den, sat);
            s.status = sat ? bts_pkg::STAT_SAT : bts_pkg::STAT_OK;
        end
        hist2_re = hist1_re; hist2_im = hist1_im;
        hist1_re = s.x_re; hist1_im = s.x_im;
        return s;
    endfunction

    // monitor: predict on row beats, track register writes, check solutions
    always @(posedge i_clk) begin
        t_sol exp_sol, got;
        if (!i_rst_n) begin
            band_order = bts_pkg::ORDER_RESET;
            hist1_re = 0; hist1_im = 0; hist2_re = 0; hist2_im = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && o_pready && i_paddr == BAND_ADDR)
                band_order = i_pwdata[1:0];
            if (row_bus.valid && row_bus.ready) begin
                exp_sol = solve_row({row_bus.first_row, row_bus.diag_re, row_bus.diag_im,
                                     row_bus.off1_re, row_bus.off1_im, row_bus.off2_re,
                                     row_bus.off2_im, row_bus.rhs_re, row_bus.rhs_im});
                solution_q.push_back(typed_flag ? typed_sol : exp_sol);
            end
            if (sol_bus.valid && sol_bus.ready) begin
                got = {sol_bus.x_re, sol_bus.x_im, sol_bus.status};
                if (solution_q.size() == 0) begin
                    $error("unexpected solution beat x_re=%h x_im=%h status=%0d",
                           got.x_re, got.x_im, got.status);
                    fail_cnt++;
                end else begin
                    exp_sol = solution_q.pop_front();
                    if (got.x_re !== exp_sol.x_re) begin
                        $error("x_re expected %h actual %h", exp_sol.x_re, got.x_re);
                        fail_cnt++;
                    end
                    if (got.x_im !== exp_sol.x_im) begin
                        $error("x_im expected %h actual %h", exp_sol.x_im, got.x_im);
                        fail_cnt++;
                    end
                    if (got.status !== exp_sol.status) begin
                        $error("status expected %0d actual %0d", exp_sol.status, got.status);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    // solution sink: random stalls plus an optional long hold-off
    initial sol_bus.ready = 1'b0;
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            sol_bus.ready = 1'b0;
            hold_cycles--;
        end else begin
            sol_bus.ready = ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic reg_write(input logic [31:0] value);
        @(negedge i_clk);
        i_psel = 1'b1; i_pwrite = 1'b1; i_paddr = BAND_ADDR; i_pwdata = value;
        @(negedge i_clk);
        i_penable = 1'b1;
        do @(posedge i_clk); while (!o_pready);
        @(negedge i_clk);
        i_psel = 1'b0; i_penable = 1'b0; i_pwrite = 1'b0;
    endtask

    // drive one row beat, holding it until accepted
    task automatic send_row(input t_row r, input int idle_pct, input logic typed,
                            input t_sol tsol);
        while ($urandom_range(0, 99) < idle_pct) @(negedge i_clk);
        row_bus.first_row = r.first_row;
        row_bus.diag_re = r.d_re;   row_bus.diag_im = r.d_im;
        row_bus.off1_re = r.c1_re;  row_bus.off1_im = r.c1_im;
        row_bus.off2_re = r.c2_re;  row_bus.off2_im = r.c2_im;
        row_bus.rhs_re = r.b_re;    row_bus.rhs_im = r.b_im;
        typed_flag = typed;
        typed_sol = tsol;
        row_bus.valid = 1'b1;
        do @(posedge i_clk); while (!row_bus.ready);
        @(negedge i_clk);
        row_bus.valid = 1'b0;
        typed_flag = 1'b0;
    endtask

    function automatic logic signed [31:0] rand_coef(input int mode, input int span);
        if (mode == 0) return $urandom;
        return $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic t_row rand_row();
        t_row r;
        int   mode;
        mode = $urandom_range(0, 9);
        r.first_row = ($urandom_range(0, 7) == 0);
        if (mode < 2) begin
            // full-range noise
            r.d_re = $urandom; r.d_im = $urandom;
            r.c1_re = $urandom; r.c1_im = $urandom;
            r.c2_re = $urandom; r.c2_im = $urandom;
            r.b_re = $urandom; r.b_im = $urandom;
        end else begin
            // well-conditioned rows keep the history in range
            r.d_re = rand_coef(1, 1 << 18); r.d_im = rand_coef(1, 1 << 16);
            r.c1_re = rand_coef(1, 1 << 16); r.c1_im = rand_coef(1, 1 << 16);
            r.c2_re = rand_coef(1, 1 << 16); r.c2_im = rand_coef(1, 1 << 16);
            r.b_re = rand_coef(1, 1 << 22); r.b_im = rand_coef(1, 1 << 22);
            if (mode == 9) begin
                r.d_re = 0; r.d_im = 0;
            end
        end
        return r;
    endfunction

    t_row directed_q[$];
    t_sol directed_exp[$];
    logic directed_typed[$];

    task automatic add_row(input t_row r, input logic typed, input t_sol s);
        directed_q.push_back(r);
        directed_typed.push_back(typed);
        directed_exp.push_back(s);
    endtask

    task automatic drain();
        while (solution_q.size() != 0) @(negedge i_clk);
        repeat (2 * DW + 40) @(negedge i_clk);
    endtask

    localparam logic signed [31:0] MAXV = 32'sh7fffffff;
    localparam logic signed [31:0] MINV = 32'sh80000000;
    localparam logic signed [31:0] ONE  = 32'sh00010000;

    // main sequence
    initial begin
        t_sol none;
        int   orders[6];
        int   idles[6];
        int   stalls[6];
        orders = '{bts_pkg::ORDER_TWO, 0, 3, bts_pkg::ORDER_TWO, bts_pkg::ORDER_RESET,
                   bts_pkg::ORDER_TWO};
        idles  = '{0, 55, 0, 22, 0, 55};
        stalls = '{0, 0, 55, 22, 0, 55};
        none = '0;
        row_bus.valid = 1'b0;
        row_bus.first_row = 1'b0;
        {row_bus.diag_re, row_bus.diag_im, row_bus.off1_re, row_bus.off1_im} = '0;
        {row_bus.off2_re, row_bus.off2_im, row_bus.rhs_re, row_bus.rhs_im} = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table, band order one after reset
        add_row('{1'b1, 0, 0, ONE, ONE, ONE, ONE, MAXV, MINV}, 1'b1,
                '{0, 0, bts_pkg::STAT_ZERO});
        add_row('{1'b0, ONE, 0, ONE, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, bts_pkg::STAT_OK});
        add_row('{1'b1, ONE, 0, 0, 0, 0, 0, MAXV, MINV}, 1'b1,
                '{MAXV, MINV, bts_pkg::STAT_OK});
        add_row('{1'b0, ONE, 0, 32'sh00018000, -ONE, MAXV, MINV, 32'sh00001234, -5},
                1'b0, none);
        add_row('{1'b0, MINV, MINV, MINV, MAXV, MAXV, MINV, MINV, MAXV}, 1'b0, none);
        add_row('{1'b1, 1, 0, 0, 0, 0, 0, MAXV, MINV}, 1'b1,
                '{MAXV, MINV, bts_pkg::STAT_SAT});
        add_row('{1'b1, 0, 1, 0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, bts_pkg::STAT_OK});
        add_row('{1'b0, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV}, 1'b0, none);
        add_row('{1'b0, 0, -ONE, -1, 1, MINV, MINV, ONE, -ONE}, 1'b0, none);
        add_row('{1'b0, -3, 7, MINV, MINV, 0, 0, MINV, MINV}, 1'b0, none);
        add_row('{1'b0, 0, 0, ONE, ONE, ONE, ONE, ONE, ONE}, 1'b1,
                '{0, 0, bts_pkg::STAT_ZERO});
        add_row('{1'b0, 2 * ONE, ONE, ONE, -ONE, ONE, ONE, 3 * ONE, ONE}, 1'b0, none);
        foreach (directed_q[k])
            send_row(directed_q[k], 0, directed_typed[k], directed_exp[k]);
        drain();

        // random phases over band orders and idle mixes
        for (int ph = 0; ph < 6; ph++) begin
            reg_write(orders[ph]);
            stall_pct = stalls[ph];
            if (ph == 4) hold_cycles = 600;
            for (int n = 0; n < 140; n++) send_row(rand_row(), idles[ph], 1'b0, none);
            drain();
        end

        stall_pct = 0;
        drain();
        if (fail_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

endmodule
